@@ src/tccw_pkg.sv @@
// Package for the text console cell writer: field widths, opcodes, defaults.
// No dependencies; imported by the channel interfaces and the top level.
package tccw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OP_W      = 3;
    localparam int CHAR_W    = 8;
    localparam int COL_IN_W  = 7;
    localparam int ROW_IN_W  = 5;
    localparam int LINEAR_W  = 11;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h02;

    // Register index as taken from paddr[2]
    localparam logic REG_ATTR = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 3'd0,
        OP_BACK   = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_SET    = 3'd3,
        OP_TOGGLE = 3'd4,
        OP_READ   = 3'd5
    } op_t;

endpackage

@@ src/tccw_if.sv @@
// Request and response channel interfaces (valid/ready) of the console writer.
// Depends on tccw_pkg for the field widths.
interface tccw_req_if;
    import tccw_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   char_code;
    logic [COL_IN_W-1:0] column;
    logic [ROW_IN_W-1:0] row;

    modport source (output valid, op, char_code, column, row, input ready);
    modport sink   (input valid, op, char_code, column, row, output ready);
endinterface

interface tccw_rsp_if;
    import tccw_pkg::*;

    logic                valid;
    logic                ready;
    logic [COL_IN_W-1:0] cursor_col;
    logic [ROW_IN_W-1:0] cursor_row;
    logic [LINEAR_W-1:0] cursor_linear;
    logic                mode_flag;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;

    modport source (output valid, cursor_col, cursor_row, cursor_linear, mode_flag,
                    cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_col, cursor_row, cursor_linear, mode_flag,
                    cell_char, cell_attr, output ready);
endinterface

@@ src/text_console_cell_writer_unit.sv @@
// Top level of the text console cell writer: screen memory, cursor, sequencer.
// Depends on tccw_pkg and the channel interfaces in tccw_if.sv.

// Character-cell console of ROWS x COLUMNS cells (80 x 25 by default). Each
// cell is 16 bits, attribute in the upper byte and character in the lower,
// held in one synchronous memory (one write port, one read port, read data
// registered). The block handles one request at a time. After reset a
// clearing pass walks the memory, writing zero to every cell, with req.ready
// low; APB writes are taken throughout. A request is taken in S_IDLE and run
// in S_EXEC (an in-range read cell then captures the registered read data in
// S_READ), and its response is loaded from S_DONE. req.ready comes back with
// the load, so the next request is taken in the cycle after at the earliest.
// Clear sweeps every cell once, one write per cycle. A put char with a scroll
// pending first moves the screen up one row by reading cell i+COLUMNS and
// writing cell i in the cycle after, one cell per cycle, blanking the bottom
// row. A finished response waits in an output register; a new request is
// accepted while it waits, and the next response is held back until the sink
// has taken the previous one. Blank cells from clear, backspace and scroll
// carry the cell_attribute register (APB address 0, reset 0x02) with
// character 0.
module text_console_cell_writer_unit #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tccw_req_if.sink                      req,
    tccw_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tccw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tccw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tccw_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tccw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);       // memory address
    localparam int CW    = $clog2(COLUMNS);     // cursor column
    localparam int RW    = $clog2(ROWS + 1);    // cursor row, ROWS = scroll pending
    localparam int LW    = $clog2(CELLS + 1);   // linear cursor position

    localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LIMIT  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL    = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW    = RW'(ROWS - 1);
    localparam logic [RW-1:0] PENDING_ROW = RW'(ROWS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_READ,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_CLEAR,
        SW_SCROLL
    } sweep_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [ATTR_W-1:0] attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTR)
        begin
            attr_reg <= pwdata[ATTR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ATTR) ? PDATA_W'(attr_reg) : '0;

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    state_t              state_reg;
    sweep_t              sweep_reg;
    logic [AW-1:0]       scan_reg;

    logic [OP_W-1:0]     op_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic [COL_IN_W-1:0] col_in_reg;
    logic [ROW_IN_W-1:0] row_in_reg;

    logic [CW-1:0]       cur_col_reg;
    logic [RW-1:0]       cur_row_reg;
    logic                mode_reg;

    logic [CHAR_W-1:0]   rd_char_reg;
    logic [ATTR_W-1:0]   rd_attr_reg;

    // write-back stage in front of the memory write port
    logic                wb_valid_reg;
    logic [AW-1:0]       wb_addr_reg;
    logic                wb_copy_reg;     // take the registered read data
    logic [CELL_W-1:0]   wb_data_reg;

    logic                rsp_valid_reg;
    logic [COL_IN_W-1:0] out_col_reg;
    logic [ROW_IN_W-1:0] out_row_reg;
    logic [LINEAR_W-1:0] out_lin_reg;
    logic                out_mode_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic [ATTR_W-1:0]   out_attr_reg;

    // memory
    logic [CELL_W-1:0]   mem [CELLS];
    logic [CELL_W-1:0]   rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic [CELL_W-1:0]   wr_data;

    // ------------------------------------------------------------------
    // Address arithmetic
    // ------------------------------------------------------------------
    logic [LW-1:0]     cur_lin;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     req_addr;
    logic              req_in_range;
    logic [CELL_W-1:0] blank;

    assign cur_lin  = LW'(LW'(cur_row_reg) * LW'(COLUMNS)) + LW'(cur_col_reg);
    assign cur_addr = AW'(cur_lin);
    assign blank    = {attr_reg, {CHAR_W{1'b0}}};

    assign req_in_range = (32'(col_in_reg) < COLUMNS) && (32'(row_in_reg) < ROWS);
    assign req_addr     = AW'(AW'(row_in_reg) * AW'(COLUMNS)) + AW'(col_in_reg);

    // Read port: scroll reads one row ahead, read cell reads the requested cell
    always_comb
    begin
        if (state_reg == S_SWEEP)
        begin
            rd_addr = scan_reg + ROW_STRIDE;
        end
        else
        begin
            rd_addr = req_addr;
        end
    end

    assign wr_data = wb_copy_reg ? rd_data_reg : wb_data_reg;

    always_ff @(posedge clk)
    begin
        if (wb_valid_reg)
        begin
            mem[wb_addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= SW_INIT;
            scan_reg      <= '0;
            op_reg        <= '0;
            char_reg      <= '0;
            col_in_reg    <= '0;
            row_in_reg    <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            mode_reg      <= 1'b0;
            rd_char_reg   <= '0;
            rd_attr_reg   <= '0;
            wb_valid_reg  <= 1'b0;
            wb_addr_reg   <= '0;
            wb_copy_reg   <= 1'b0;
            wb_data_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_lin_reg   <= '0;
            out_mode_reg  <= 1'b0;
            out_char_reg  <= '0;
            out_attr_reg  <= '0;
        end
        else
        begin
            wb_valid_reg <= 1'b0;
            wb_copy_reg  <= 1'b0;

            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg     <= req.op;
                        char_reg   <= req.char_code;
                        col_in_reg <= req.column;
                        row_in_reg <= req.row;
                        state_reg  <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    rd_char_reg <= '0;
                    rd_attr_reg <= '0;
                    state_reg   <= S_DONE;
                    case (op_reg)
                        OP_PUT:
                        begin
                            if (cur_row_reg == PENDING_ROW)
                            begin
                                // scroll first, then come back here
                                sweep_reg <= SW_SCROLL;
                                scan_reg  <= '0;
                                state_reg <= S_SWEEP;
                            end
                            else
                            begin
                                wb_valid_reg <= 1'b1;
                                wb_addr_reg  <= cur_addr;
                                wb_data_reg  <= {attr_reg, char_reg};
                                if (cur_col_reg == LAST_COL)
                                begin
                                    cur_col_reg <= '0;
                                    cur_row_reg <= cur_row_reg + 1'b1;
                                end
                                else
                                begin
                                    cur_col_reg <= cur_col_reg + 1'b1;
                                end
                            end
                        end

                        OP_BACK:
                        begin
                            // a step back is always one linear cell back
                            if (cur_col_reg != '0 || cur_row_reg != '0)
                            begin
                                wb_valid_reg <= 1'b1;
                                wb_addr_reg  <= cur_addr - 1'b1;
                                wb_data_reg  <= blank;
                                if (cur_col_reg == '0)
                                begin
                                    cur_col_reg <= LAST_COL;
                                    cur_row_reg <= cur_row_reg - 1'b1;
                                end
                                else
                                begin
                                    cur_col_reg <= cur_col_reg - 1'b1;
                                end
                            end
                        end

                        OP_CLEAR:
                        begin
                            cur_col_reg <= '0;
                            cur_row_reg <= '0;
                            sweep_reg   <= SW_CLEAR;
                            scan_reg    <= '0;
                            state_reg   <= S_SWEEP;
                        end

                        OP_SET:
                        begin
                            cur_col_reg <= (32'(col_in_reg) < COLUMNS) ? CW'(col_in_reg)
                                                                       : LAST_COL;
                            cur_row_reg <= (32'(row_in_reg) < ROWS) ? RW'(row_in_reg)
                                                                    : LAST_ROW;
                        end

                        OP_TOGGLE:
                        begin
                            mode_reg <= ~mode_reg;
                        end

                        OP_READ:
                        begin
                            // read was issued this cycle on req_addr
                            if (req_in_range)
                            begin
                                state_reg <= S_READ;
                            end
                        end

                        default:
                        begin
                        end
                    endcase
                end

                S_SWEEP:
                begin
                    wb_valid_reg <= 1'b1;
                    wb_addr_reg  <= scan_reg;
                    case (sweep_reg)
                        SW_INIT:
                        begin
                            wb_data_reg <= '0;
                        end
                        SW_SCROLL:
                        begin
                            wb_data_reg <= blank;
                            wb_copy_reg <= (scan_reg < COPY_LIMIT);
                        end
                        default:
                        begin
                            wb_data_reg <= blank;
                        end
                    endcase

                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == LAST_CELL)
                    begin
                        case (sweep_reg)
                            SW_INIT:
                            begin
                                state_reg <= S_IDLE;
                            end
                            SW_SCROLL:
                            begin
                                cur_col_reg <= '0;
                                cur_row_reg <= LAST_ROW;
                                state_reg   <= S_EXEC;
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_READ:
                begin
                    rd_char_reg <= rd_data_reg[CHAR_W-1:0];
                    rd_attr_reg <= rd_data_reg[CELL_W-1:CHAR_W];
                    state_reg   <= S_DONE;
                end

                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        out_col_reg   <= COL_IN_W'(cur_col_reg);
                        out_row_reg   <= ROW_IN_W'(cur_row_reg);
                        out_lin_reg   <= LINEAR_W'(cur_lin);
                        out_mode_reg  <= mode_reg;
                        out_char_reg  <= rd_char_reg;
                        out_attr_reg  <= rd_attr_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready         = (state_reg == S_IDLE);

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.cursor_col    = out_col_reg;
    assign rsp.cursor_row    = out_row_reg;
    assign rsp.cursor_linear = out_lin_reg;
    assign rsp.mode_flag     = out_mode_reg;
    assign rsp.cell_char     = out_char_reg;
    assign rsp.cell_attr     = out_attr_reg;

endmodule

@@ tb/sv/text_console_cell_writer_check.sv @@
// Checker for the text console cell writer: keeps a shadow screen, cursor and
// mode, predicts one status per request and compares it with each response.
// Depends on tccw_pkg and the channel interfaces in tccw_if.sv.
module text_console_cell_writer_check (
    input  logic                          clk,
    input  logic                          rst_n,
    tccw_req_if                           req_mon,
    tccw_rsp_if                           rsp_mon,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [tccw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tccw_pkg::PDATA_W-1:0]  pwdata,
    output int                            mismatch_count,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import tccw_pkg::*;

    localparam int SCREEN_SIZE = COLUMNS_DEF * ROWS_DEF;
    localparam logic [PADDR_W-1:0] ATTR_ADDR = '0;

    typedef struct packed {
        logic [COL_IN_W-1:0] cursor_col;
        logic [ROW_IN_W-1:0] cursor_row;
        logic [LINEAR_W-1:0] cursor_linear;
        logic                mode_flag;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
    } console_status_t;

    logic [CELL_W-1:0]   screen_copy [SCREEN_SIZE];
    logic [COL_IN_W-1:0] cursor_col_q;
    logic [ROW_IN_W-1:0] cursor_row_q;
    logic                mode_q;
    logic [ATTR_W-1:0]   attr_q;
    console_status_t     status_expected [$];

    function automatic int cell_index(input int c, input int r);
        return r * COLUMNS_DEF + c;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    task automatic scroll_screen();
        for (int i = 0; i < SCREEN_SIZE; i++)
            screen_copy[i] = (i < SCREEN_SIZE - COLUMNS_DEF) ?
                             screen_copy[i + COLUMNS_DEF] : {attr_q, CHAR_W'(0)};
        cursor_col_q = '0;
        cursor_row_q = ROW_IN_W'(ROWS_DEF - 1);
    endtask

    task automatic apply_console_op(input logic [OP_W-1:0]     op,
                                    input logic [CHAR_W-1:0]   ch,
                                    input logic [COL_IN_W-1:0] col,
                                    input logic [ROW_IN_W-1:0] row);
        console_status_t s;
        s = '0;
        case (op)
            OP_PUT:
            begin
                if (cursor_row_q >= ROWS_DEF)
                    scroll_screen();
                screen_copy[cell_index(cursor_col_q, cursor_row_q)] = {attr_q, ch};
                if (cursor_col_q == COLUMNS_DEF - 1)
                begin
                    cursor_col_q = '0;
                    cursor_row_q = cursor_row_q + 1'b1;
                end
                else
                    cursor_col_q = cursor_col_q + 1'b1;
            end
            OP_BACK:
            begin
                if (cursor_col_q != 0 || cursor_row_q != 0)
                begin
                    // column 0 wraps to the last column of the row above
                    if (cursor_col_q == 0)
                    begin
                        cursor_col_q = COL_IN_W'(COLUMNS_DEF - 1);
                        cursor_row_q = cursor_row_q - 1'b1;
                    end
                    else
                        cursor_col_q = cursor_col_q - 1'b1;
                    screen_copy[cell_index(cursor_col_q, cursor_row_q)] = {attr_q, CHAR_W'(0)};
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SCREEN_SIZE; i++)
                    screen_copy[i] = {attr_q, CHAR_W'(0)};
                cursor_col_q = '0;
                cursor_row_q = '0;
            end
            OP_SET:
            begin
                cursor_col_q = (col < COLUMNS_DEF) ? col : COL_IN_W'(COLUMNS_DEF - 1);
                cursor_row_q = (row < ROWS_DEF) ? row : ROW_IN_W'(ROWS_DEF - 1);
            end
            OP_TOGGLE:
                mode_q = ~mode_q;
            OP_READ:
            begin
                if (col < COLUMNS_DEF && row < ROWS_DEF)
                    {s.cell_attr, s.cell_char} = screen_copy[cell_index(col, row)];
            end
            default: ;
        endcase
        s.cursor_col    = cursor_col_q;
        s.cursor_row    = cursor_row_q;
        s.cursor_linear = LINEAR_W'(int'(cursor_row_q) * COLUMNS_DEF + int'(cursor_col_q));
        s.mode_flag     = mode_q;
        status_expected.push_back(s);
    endtask

    task automatic compare_status();
        console_status_t want;
        if (status_expected.size() == 0)
        begin
            report_mismatch("response with no request outstanding");
            return;
        end
        want = status_expected.pop_front();
        check_field("cursor_col", want.cursor_col, rsp_mon.cursor_col);
        check_field("cursor_row", want.cursor_row, rsp_mon.cursor_row);
        check_field("cursor_linear", want.cursor_linear, rsp_mon.cursor_linear);
        check_field("mode_flag", want.mode_flag, rsp_mon.mode_flag);
        check_field("cell_char", want.cell_char, rsp_mon.cell_char);
        check_field("cell_attr", want.cell_attr, rsp_mon.cell_attr);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCREEN_SIZE; i++)
                screen_copy[i] = '0;
            cursor_col_q = '0;
            cursor_row_q = '0;
            mode_q       = 1'b0;
            attr_q       = ATTR_RESET;
            status_expected.delete();
            outstanding  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ATTR_ADDR)
                attr_q = pwdata[ATTR_W-1:0];
            // response first: a request taken at this edge cannot answer at it
            if (rsp_mon.valid && rsp_mon.ready)
                compare_status();
            if (req_mon.valid && req_mon.ready)
                apply_console_op(req_mon.op, req_mon.char_code, req_mon.column, req_mon.row);
            outstanding = status_expected.size();
        end
    end

endmodule

@@ tb/sv/text_console_cell_writer_unit_test.sv @@
// Top of the console writer testbench: clock, reset, request and APB stimulus,
// response back-pressure and the verdict. Depends on tccw_pkg, tccw_if.sv, the
// RTL top and text_console_cell_writer_check.sv.
module text_console_cell_writer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tccw_pkg::*;

    // opcodes the block has no use for; they must leave everything alone
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // register 0 sits at byte 0; byte 4 decodes to no register at all
    localparam logic [PADDR_W-1:0] ATTR_ADDR  = 3'd0;
    localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;

    localparam logic [COL_IN_W-1:0] LAST_COL = COL_IN_W'(COLUMNS_DEF - 1);
    localparam logic [ROW_IN_W-1:0] LAST_ROW = ROW_IN_W'(ROWS_DEF - 1);
    localparam logic [COL_IN_W-1:0] MAX_COL  = '1;
    localparam logic [ROW_IN_W-1:0] MAX_ROW  = '1;

    localparam int MAX_GAP     = 6;
    localparam int HOLD_CYCLES = 250;  // long enough to back the block up
    localparam int DRAIN       = 16;   // idle margin past the last response

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatch_count;
    int outstanding;

    bit no_idle;      // both sides run flat out while set
    bit hold_output;  // asks the response side for one long stall

    // last position handed to set cursor; reads aim near it to hit written cells
    logic [COL_IN_W-1:0] aim_col;
    logic [ROW_IN_W-1:0] aim_row;

    tccw_req_if req_ch();
    tccw_rsp_if rsp_ch();

    text_console_cell_writer_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    text_console_cell_writer_check screen_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_mon        (req_ch),
        .rsp_mon        (rsp_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one request and return at the edge that takes it. valid stays
    // high on return so back-to-back requests never drop it in between; it
    // is lowered only when the next request draws a gap, or by settle.
    task automatic send_request(input logic [OP_W-1:0]     op,
                                input logic [CHAR_W-1:0]   ch,
                                input logic [COL_IN_W-1:0] col,
                                input logic [ROW_IN_W-1:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.char_code <= ch;
        req_ch.column    <= col;
        req_ch.row       <= row;
        do @(posedge clk); while (!req_ch.ready);
        if (op == OP_SET)
        begin
            aim_col = col;
            aim_row = row;
        end
    endtask

    // Stop offering and wait until every response has come back. Every
    // request answers, so an empty checker queue means the block is idle.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One request drawn by weight: mostly put char and reads, a few clears
    // since each one sweeps the whole screen.
    task automatic random_request();
        int pick;
        int sel;
        int c;
        logic [COL_IN_W-1:0] col;
        logic [ROW_IN_W-1:0] row;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_request(OP_PUT, $urandom, $urandom, $urandom);
        else if (pick < 57)
            send_request(OP_BACK, $urandom, $urandom, $urandom);
        else if (pick < 59)
            send_request(OP_CLEAR, $urandom, $urandom, $urandom);
        else if (pick < 70)
        begin
            // mostly in range, sometimes past the edge to exercise saturation
            col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, COLUMNS_DEF - 1)
                                               : $urandom_range(COLUMNS_DEF, 127);
            row = ($urandom_range(0, 99) < 85) ? $urandom_range(0, ROWS_DEF - 1)
                                               : $urandom_range(ROWS_DEF, 31);
            send_request(OP_SET, $urandom, col, row);
        end
        else if (pick < 75)
            send_request(OP_TOGGLE, $urandom, $urandom, $urandom);
        else if (pick < 95)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
            begin
                // near the last set cursor, where puts have likely landed
                c = int'(aim_col) + int'($urandom_range(0, 8)) - 4;
                if (c < 0)
                    c = 0;
                if (c > COLUMNS_DEF - 1)
                    c = COLUMNS_DEF - 1;
                col = COL_IN_W'(c);
                row = aim_row;
            end
            else if (sel < 9)
            begin
                col = $urandom_range(0, COLUMNS_DEF - 1);
                row = $urandom_range(0, ROWS_DEF - 1);
            end
            else
            begin
                col = $urandom;
                row = $urandom;
            end
            send_request(OP_READ, $urandom, col, row);
        end
        else
            send_request($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                         $urandom, $urandom, $urandom);
    endtask

    // Random traffic: weighted single requests, runs of puts at the bottom
    // row that can force a scroll, and a share of raw noise over every field.
    task automatic random_phase(input int count);
        int done;
        int pick;
        int run_len;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                run_len = $urandom_range(3, 8);
                send_request(OP_SET, $urandom, $urandom_range(COLUMNS_DEF - 6, COLUMNS_DEF - 1),
                             LAST_ROW);
                repeat (run_len)
                    send_request(OP_PUT, $urandom, $urandom, $urandom);
                // if a scroll happened, the row that was at the bottom has moved up by one
                send_request(OP_READ, $urandom, $urandom_range(COLUMNS_DEF - 10, COLUMNS_DEF - 1),
                             LAST_ROW - 1'b1);
                done += run_len + 2;
            end
            else if (pick < 88)
            begin
                random_request();
                done++;
            end
            else
            begin
                send_request($urandom_range(0, 7), $urandom, $urandom, $urandom);
                done++;
            end
        end
    endtask

    // Hand-picked start: reset contents, home backspace, saturating set,
    // scroll pending and the backspace that cancels it, a real scroll,
    // out-of-range reads, wrap to the previous row, spare opcodes, clear.
    task automatic directed_phase();
        send_request(OP_READ, 8'h00, 7'd0, 5'd0);
        send_request(OP_BACK, 8'h00, 7'd0, 5'd0);
        send_request(OP_PUT, 8'hFF, 7'd0, 5'd0);
        send_request(OP_READ, 8'h00, 7'd0, 5'd0);
        send_request(OP_TOGGLE, 8'h00, 7'd0, 5'd0);
        send_request(OP_SPARE_A, 8'h00, 7'd0, 5'd0);
        send_request(OP_SPARE_B, 8'hFF, MAX_COL, MAX_ROW);
        send_request(OP_SET, 8'h00, MAX_COL, MAX_ROW);
        send_request(OP_PUT, 8'h00, 7'd0, 5'd0);
        send_request(OP_READ, 8'h00, LAST_COL, LAST_ROW);
        send_request(OP_BACK, 8'h00, 7'd0, 5'd0);
        send_request(OP_READ, 8'h00, LAST_COL, LAST_ROW);
        send_request(OP_PUT, 8'h41, 7'd0, 5'd0);
        send_request(OP_PUT, 8'h42, 7'd0, 5'd0);
        send_request(OP_READ, 8'h00, LAST_COL, LAST_ROW - 1'b1);
        send_request(OP_READ, 8'h00, 7'd0, LAST_ROW);
        send_request(OP_READ, 8'h00, 7'd1, LAST_ROW);
        send_request(OP_READ, 8'h00, MAX_COL, MAX_ROW);
        send_request(OP_READ, 8'h00, LAST_COL + 1'b1, 5'd0);
        send_request(OP_READ, 8'h00, 7'd0, LAST_ROW + 1'b1);
        send_request(OP_SET, 8'h00, 7'd0, 5'd1);
        send_request(OP_BACK, 8'h00, 7'd0, 5'd0);
        send_request(OP_TOGGLE, 8'h00, 7'd0, 5'd0);
        send_request(OP_CLEAR, 8'h00, 7'd0, 5'd0);
        send_request(OP_READ, 8'h00, 7'd0, 5'd0);
    endtask

    // Response side: a fresh random stall per response, plus one long hold
    // on request from the stimulus thread.
    initial
    begin
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        aim_col = '0;
        aim_row = '0;
        no_idle = 1'b0;
        hold_output = 1'b0;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.op        <= OP_PUT;
        req_ch.char_code <= '0;
        req_ch.column    <= '0;
        req_ch.row       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset attribute; ready stays low through the clearing pass
        directed_phase();

        // brightest attribute; a write to the unused address must be ignored
        settle();
        apb_write(ATTR_ADDR, 32'h0000_00FF);
        apb_write(SPARE_ADDR, 32'h0000_0055);
        random_phase(140);

        // attribute zero with junk above the byte, both sides flat out
        settle();
        apb_write(ATTR_ADDR, 32'hFFFF_FF00);
        no_idle = 1'b1;
        random_phase(100);

        // long output stall while requests keep coming: the response
        // register fills and the block stops taking requests
        hold_output = 1'b1;
        repeat (8)
            send_request(OP_PUT, $urandom, $urandom, $urandom);
        no_idle = 1'b0;

        settle();
        apb_write(ATTR_ADDR, PDATA_W'($urandom_range(1, 254)));
        random_phase(130);

        settle();
        apb_write(ATTR_ADDR, 32'h0000_000E);
        random_phase(50);

        settle();
        repeat (DRAIN) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hang guard: far beyond a run where every request scrolls and every
    // response waits out the longest stall.
    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
